@@ sv/zzs_pkg.sv @@
`timescale 1ns / 1ps

package zzs_pkg;

  localparam int ZZS_MAX_ROWS   = 8;
  localparam int ZZS_MAX_COLS   = 8;
  localparam int ZZS_DATA_WIDTH = 16;

  localparam int COEFF_W   = 16;
  localparam int POS_OUT_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;
  localparam int SIZE_W    = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION = 2'd0,
    CFG_ROW_COUNT = 2'd1,
    CFG_COL_COUNT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic zigzag;
  } walk_ctrl_t;

endpackage

@@ sv/zzs_walk.sv @@
`timescale 1ns / 1ps

module zzs_walk import zzs_pkg::*; #(
  parameter int MAX_ROWS = ZZS_MAX_ROWS,
  parameter int MAX_COLS = ZZS_MAX_COLS,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int NW = $clog2(MAX_ROWS + 1),
  localparam int MW = $clog2(MAX_COLS + 1),
  localparam int AW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  walk_ctrl_t    ctrl,
  input  logic [NW-1:0] n,
  input  logic [MW-1:0] m,
  output logic [RW-1:0] row,
  output logic [CW-1:0] col,
  output logic [AW-1:0] addr
);

  localparam int PW = RW + MW + 1;

  logic [RW-1:0] r, r_next;
  logic [CW-1:0] c, c_next;
  logic [RW-1:0] r_last;
  logic [CW-1:0] c_last;
  logic [PW-1:0] prod;

  assign r_last = RW'(n - NW'(1));
  assign c_last = CW'(m - MW'(1));

  always_comb begin
    r_next = r;
    c_next = c;
    if (ctrl.zigzag) begin
      if ((r[0] ^ c[0]) == 1'b0) begin
        // up and to the right
        if (c == c_last) begin
          r_next = RW'(r + 1'b1);
        end else if (r == '0) begin
          c_next = CW'(c + 1'b1);
        end else begin
          r_next = RW'(r - 1'b1);
          c_next = CW'(c + 1'b1);
        end
      end else begin
        // down and to the left
        if (r == r_last) begin
          c_next = CW'(c + 1'b1);
        end else if (c == '0) begin
          r_next = RW'(r + 1'b1);
        end else begin
          r_next = RW'(r + 1'b1);
          c_next = CW'(c - 1'b1);
        end
      end
    end else begin
      if (c == c_last) begin
        c_next = '0;
        r_next = RW'(r + 1'b1);
      end else begin
        c_next = CW'(c + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      r <= '0;
      c <= '0;
    end else if (ctrl.step) begin
      r <= r_next;
      c <= c_next;
    end
  end

  assign prod = PW'(r) * PW'(m) + PW'(c);
  assign addr = prod[AW-1:0];
  assign row  = r;
  assign col  = c;

endmodule

@@ sv/zigzag_scan_reorder.sv @@
`timescale 1ns / 1ps

// zigzag scan reorder for one block of row_count x col_count coefficients
// input channel: in_valid/in_ready with coeff_value, one coefficient a beat
// output channel: out_valid/out_ready with coeff_value_out, out_row, out_col
//   and last_of_block on the final beat of each block
// config: cfg_valid/cfg_ready, always ready; cfg_index selects direction,
//   row_count or col_count, for the user to write only while idle (unenforced)
// direction 0: raster in, zigzag out; direction 1: zigzag in, raster out
// loading takes a beat whenever in_valid and in_ready are high; in_ready is
//   low from the final load beat until the block's last result sits in the
//   output register; forward: each result is read from the store in S_RD,
//   then loaded in S_OUT, paced by the single walker and store read port
// inverse: first a permutation pass into the raster buffer (S_PRD reads and
//   S_PWR writes each coefficient), then results follow as in forward mode
// a stalled receiver holds the output register and the walker waits
// reset: direction 0, row_count 8, col_count 8, empty block, no result;
//   the coefficient stores are not cleared
module zigzag_scan_reorder import zzs_pkg::*; #(
  parameter int MAX_ROWS   = ZZS_MAX_ROWS,
  parameter int MAX_COLS   = ZZS_MAX_COLS,
  parameter int DATA_WIDTH = ZZS_DATA_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [COEFF_W-1:0]  coeff_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [COEFF_W-1:0]  coeff_value_out,
  output logic [POS_OUT_W-1:0]       out_row,
  output logic [POS_OUT_W-1:0]       out_col,
  output logic                       last_of_block,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DAT_W-1:0]       cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NW = $clog2(MAX_ROWS + 1);
  localparam int MW = $clog2(MAX_COLS + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW = $clog2(DEPTH + 1);
  localparam int SW = (DATA_WIDTH < COEFF_W) ? DATA_WIDTH : COEFF_W;
  localparam logic signed [COEFF_W-1:0] SAT_HI = COEFF_W'((1 << (SW - 1)) - 1);
  localparam logic signed [COEFF_W-1:0] SAT_LO = COEFF_W'(-(1 << (SW - 1)));

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_PRD  = 5'b00010,
    S_PWR  = 5'b00100,
    S_RD   = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic                direction;
  logic [SIZE_W-1:0]   row_count;
  logic [SIZE_W-1:0]   col_count;
  logic [NW-1:0]       n;
  logic [MW-1:0]       m;
  logic [TW-1:0]       total;
  logic [TW-1:0]       load_count;
  logic [TW-1:0]       emit_count;
  logic                emit_last;
  logic                block_done;
  logic                in_beat;
  logic                out_free;
  logic                out_load;

  logic signed [COEFF_W-1:0] sat_value;
  logic signed [SW-1:0]      coeff_mem [DEPTH];
  logic signed [SW-1:0]      raster_mem [DEPTH];
  logic signed [SW-1:0]      coeff_rd;
  logic signed [SW-1:0]      raster_rd;
  logic [AW-1:0]             coeff_rd_addr;

  walk_ctrl_t          walk_ctrl;
  logic [RW-1:0]       walk_row;
  logic [CW-1:0]       walk_col;
  logic [AW-1:0]       walk_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      row_count <= SIZE_W'(8);
      col_count <= SIZE_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIRECTION: direction <= cfg_data[0];
        CFG_ROW_COUNT: row_count <= cfg_data;
        CFG_COL_COUNT: col_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // sizes out of range clamp to 1 .. max
  always_comb begin
    if (row_count == '0) begin
      n = NW'(1);
    end else if (32'(row_count) > MAX_ROWS) begin
      n = NW'(MAX_ROWS);
    end else begin
      n = NW'(row_count);
    end
    if (col_count == '0) begin
      m = MW'(1);
    end else if (32'(col_count) > MAX_COLS) begin
      m = MW'(MAX_COLS);
    end else begin
      m = MW'(col_count);
    end
  end

  assign total      = TW'(n) * TW'(m);
  assign block_done = ({1'b0, load_count} + 1'b1) >= {1'b0, total};
  assign emit_last  = (emit_count == TW'(total - 1'b1));
  assign in_ready   = (state == S_LOAD);
  assign in_beat    = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign out_load   = (state == S_OUT) && out_free;

  always_comb begin
    if (coeff_value > SAT_HI) begin
      sat_value = SAT_HI;
    end else if (coeff_value < SAT_LO) begin
      sat_value = SAT_LO;
    end else begin
      sat_value = coeff_value;
    end
  end

  always_comb begin
    walk_ctrl.clear  = (in_beat && block_done) || ((state == S_PWR) && emit_last);
    walk_ctrl.step   = ((state == S_PWR) && !emit_last) || out_load;
    walk_ctrl.zigzag = (state == S_PWR) || !direction;
  end

  zzs_walk #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_walk (
    .clk  (clk),
    .rst  (rst),
    .ctrl (walk_ctrl),
    .n    (n),
    .m    (m),
    .row  (walk_row),
    .col  (walk_col),
    .addr (walk_addr)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (in_beat && block_done) begin
          state_next = direction ? S_PRD : S_RD;
        end
      end
      S_PRD: state_next = S_PWR;
      S_PWR: state_next = emit_last ? S_RD : S_PRD;
      S_RD:  state_next = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_next = emit_last ? S_LOAD : S_RD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      emit_count <= '0;
    end else begin
      state <= state_next;
      if (in_beat) begin
        load_count <= block_done ? '0 : TW'(load_count + 1'b1);
        emit_count <= '0;
      end
      if (state == S_PWR || out_load) begin
        emit_count <= emit_last ? '0 : TW'(emit_count + 1'b1);
      end
    end
  end

  assign coeff_rd_addr = (state == S_PRD) ? emit_count[AW-1:0] : walk_addr;

  always_ff @(posedge clk) begin
    if (in_beat) begin
      coeff_mem[load_count[AW-1:0]] <= SW'(sat_value);
    end
    coeff_rd <= coeff_mem[coeff_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_PWR) begin
      raster_mem[walk_addr] <= coeff_rd;
    end
    raster_rd <= raster_mem[walk_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      coeff_value_out <= direction ? COEFF_W'(raster_rd) : COEFF_W'(coeff_rd);
      out_row         <= POS_OUT_W'(walk_row);
      out_col         <= POS_OUT_W'(walk_col);
      last_of_block   <= emit_last;
    end
  end

`ifndef ASSERT_OFF
  // walker stays inside the block in use
  a_walk_in_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> ({1'b0, walk_addr} < (AW + 1)'(total)))
    else $error("walker address outside the block");

  // emission count never runs past the block
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (emit_count < total))
    else $error("emission count past end of block");

  // after the last result is loaded the block is ready for a fresh load
  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (out_load && emit_last) |=> (state == S_LOAD) && (load_count == '0) && last_of_block)
    else $error("block end not followed by an empty load");

  // loading never overlaps emission
  a_no_load_in_emit: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |=> !(in_beat && $stable(state) && (state != S_LOAD)))
    else $error("input beat taken during emission");
`endif

endmodule

@@ verif/zigzag_scan_checker.sv @@
`timescale 1ns / 1ps

module zigzag_scan_checker import zzs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [COEFF_W-1:0] coeff_value,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [COEFF_W-1:0] coeff_value_out,
  input  logic [POS_OUT_W-1:0]      out_row,
  input  logic [POS_OUT_W-1:0]      out_col,
  input  logic                      last_of_block,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DAT_W-1:0]      cfg_data,
  output int                        fault_count,
  output int                        results_owed
);

  localparam int BLOCK_MAX = ZZS_MAX_ROWS * ZZS_MAX_COLS;
  localparam int RESET_DIM = 8;

  typedef struct packed {
    logic [COEFF_W-1:0]   coeff;
    logic [POS_OUT_W-1:0] row;
    logic [POS_OUT_W-1:0] col;
    logic                 last;
  } coeff_beat_t;

  coeff_beat_t        owed_beats[$];
  logic [COEFF_W-1:0] gathered [BLOCK_MAX];
  logic [COEFF_W-1:0] raster_buf [BLOCK_MAX];
  int                 scan_pos [BLOCK_MAX];
  int                 gather_count;
  logic               inverse_mode;
  logic [SIZE_W-1:0]  rows_reg;
  logic [SIZE_W-1:0]  cols_reg;

  initial begin
    fault_count  = 0;
    results_owed = 0;
  end

  function automatic int clamp_dim(input logic [SIZE_W-1:0] v, input int dim_max);
    if (v == 0) return 1;
    if (int'(v) > dim_max) return dim_max;
    return int'(v);
  endfunction

  task automatic report_fault(input string what);
    $display("%0t ns  %s", $time, what);
    fault_count++;
  endtask

  // raster index of each scan position; even diagonals climb, odd ones descend
  task automatic walk_zigzag(input int n, input int m);
    int k;
    int y;
    int x;
    k = 0;
    for (int d = 0; d < n + m - 1; d++) begin
      if (d % 2 == 0) begin
        for (y = (d < n - 1) ? d : n - 1; y >= 0 && d - y < m; y--) begin
          scan_pos[k] = y * m + d - y;
          k++;
        end
      end else begin
        for (x = (d < m - 1) ? d : m - 1; x >= 0 && d - x < n; x--) begin
          scan_pos[k] = (d - x) * m + x;
          k++;
        end
      end
    end
  endtask

  task automatic emit_block(input int n, input int m);
    int total;
    int p;
    coeff_beat_t beat;
    total = n * m;
    walk_zigzag(n, m);
    if (inverse_mode) begin
      for (int k = 0; k < total; k++) raster_buf[scan_pos[k]] = gathered[k];
    end
    for (int k = 0; k < total; k++) begin
      p         = inverse_mode ? k : scan_pos[k];
      beat.coeff = inverse_mode ? raster_buf[k] : gathered[p];
      beat.row  = POS_OUT_W'(p / m);
      beat.col  = POS_OUT_W'(p % m);
      beat.last = (k == total - 1);
      owed_beats = {owed_beats, beat};
    end
  endtask

  // data width matches the port, so saturation never bites
  task automatic take_coeff(input logic [COEFF_W-1:0] v);
    int n;
    int m;
    n = clamp_dim(rows_reg, ZZS_MAX_ROWS);
    m = clamp_dim(cols_reg, ZZS_MAX_COLS);
    if (gather_count < BLOCK_MAX) gathered[gather_count] = v;
    gather_count++;
    if (gather_count >= n * m) begin
      gather_count = 0;
      emit_block(n, m);
    end
  endtask

  task automatic take_write(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DAT_W-1:0] data);
    case (idx)
      CFG_DIRECTION: inverse_mode = data[0];
      CFG_ROW_COUNT: rows_reg = data;
      CFG_COL_COUNT: cols_reg = data;
      default: ;
    endcase
  endtask

  task automatic check_beat();
    coeff_beat_t got;
    coeff_beat_t want;
    got = '{coeff_value_out, out_row, out_col, last_of_block};
    if (owed_beats.size() == 0) begin
      report_fault($sformatf("unexpected result: value %0d row %0d col %0d last %0b",
                             $signed(got.coeff), got.row, got.col, got.last));
    end else begin
      want = owed_beats.pop_front();
      if (got !== want) begin
        report_fault($sformatf({"result mismatch: want value %0d row %0d col %0d last %0b,",
                                " got value %0d row %0d col %0d last %0b"},
                               $signed(want.coeff), want.row, want.col, want.last,
                               $signed(got.coeff), got.row, got.col, got.last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      owed_beats.delete();
      gather_count = 0;
      inverse_mode = 1'b0;
      rows_reg     = SIZE_W'(RESET_DIM);
      cols_reg     = SIZE_W'(RESET_DIM);
      results_owed <= 0;
    end else begin
      if (out_valid && out_ready) check_beat();
      if (cfg_valid && cfg_ready) take_write(cfg_index, cfg_data);
      if (in_valid && in_ready) take_coeff(coeff_value);
      results_owed <= owed_beats.size();
    end
  end

endmodule

@@ verif/zigzag_scan_reorder_test.sv @@
`timescale 1ns / 1ps

module zigzag_scan_reorder_test;
  import zzs_pkg::*;

  localparam int RANDOM_ITEMS  = 185;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 40;
  localparam int CYCLE_LIMIT   = 100000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [COEFF_W-1:0] coeff_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b1;
  logic signed [COEFF_W-1:0] coeff_value_out;
  logic [POS_OUT_W-1:0]      out_row;
  logic [POS_OUT_W-1:0]      out_col;
  logic                      last_of_block;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = CFG_DIRECTION;
  logic [CFG_DAT_W-1:0]      cfg_data = '0;
  logic                      calm = 1'b0;
  int                        fault_count;
  int                        results_owed;
  int                        cycle_count = 0;

  zigzag_scan_reorder u_dut (.*);

  zigzag_scan_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    out_ready <= rst || calm || ($urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_coeff(input logic signed [COEFF_W-1:0] v);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    coeff_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes run on without a gap
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int eff_dim(input logic [CFG_DAT_W-1:0] v, input int dim_max);
    return (v == 0) ? 1 : ((int'(v) > dim_max) ? dim_max : int'(v));
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_dim();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return CFG_DAT_W'($urandom_range(1, 4));
    if (roll < 9) return CFG_DAT_W'($urandom_range(5, 8));
    return ($urandom_range(0, 1) == 1) ? '0 : CFG_DAT_W'($urandom_range(9, 15));
  endfunction

  function automatic logic signed [COEFF_W-1:0] pick_coeff();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return COEFF_W'(int'($urandom_range(0, 64)) - 32);
      default: return COEFF_W'($urandom());
    endcase
  endfunction

  initial begin
    int phase;
    int sent;
    int total;
    int n_items;
    logic dir_pick;
    logic [CFG_DAT_W-1:0] rows_pick;
    logic [CFG_DAT_W-1:0] cols_pick;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // single-coefficient blocks at both extremes
    write_reg(CFG_DIRECTION, 4'd0);
    write_reg(CFG_ROW_COUNT, 4'd1);
    write_reg(CFG_COL_COUNT, 4'd1);
    cfg_valid <= 1'b0;
    send_coeff(16'sh7FFF);
    send_coeff(16'sh8000);
    settle();

    // zero sizes clamp up to one, spare index does nothing
    write_reg(CFG_ROW_COUNT, 4'd0);
    write_reg(CFG_COL_COUNT, 4'd0);
    write_reg(CFG_SPARE, 4'd15);
    cfg_valid <= 1'b0;
    send_coeff(-16'sd1);
    settle();

    // inverse on a 2x3 block, upper data bits ignored for direction
    write_reg(CFG_DIRECTION, 4'd15);
    write_reg(CFG_ROW_COUNT, 4'd2);
    write_reg(CFG_COL_COUNT, 4'd3);
    cfg_valid <= 1'b0;
    send_coeff(16'sh0000);
    send_coeff(16'sh0001);
    send_coeff(16'shFFFF);
    send_coeff(16'sh5555);
    send_coeff(16'shAAAA);
    send_coeff(16'sh7FFF);
    settle();

    // oversized row count clamps to the maximum, single column
    write_reg(CFG_DIRECTION, 4'd14);
    write_reg(CFG_ROW_COUNT, 4'd15);
    write_reg(CFG_COL_COUNT, 4'd1);
    cfg_valid <= 1'b0;
    repeat (8) send_coeff(pick_coeff());
    settle();

    // shrink the block and flip direction part way through loading
    write_reg(CFG_DIRECTION, 4'd1);
    write_reg(CFG_ROW_COUNT, 4'd3);
    write_reg(CFG_COL_COUNT, 4'd3);
    cfg_valid <= 1'b0;
    repeat (5) send_coeff(pick_coeff());
    settle();
    write_reg(CFG_DIRECTION, 4'd0);
    write_reg(CFG_ROW_COUNT, 4'd1);
    write_reg(CFG_COL_COUNT, 4'd2);
    cfg_valid <= 1'b0;
    send_coeff(pick_coeff());
    settle();

    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      calm      <= (phase >= 3 && phase < 7);
      dir_pick  = $urandom_range(0, 1);
      rows_pick = (phase == 0) ? CFG_DAT_W'(8) : pick_dim();
      cols_pick = (phase == 0) ? CFG_DAT_W'(8) : pick_dim();
      write_reg(CFG_DIRECTION, {(CFG_DAT_W-1)'($urandom_range(0, 7)), dir_pick});
      write_reg(CFG_ROW_COUNT, rows_pick);
      write_reg(CFG_COL_COUNT, cols_pick);
      cfg_valid <= 1'b0;
      total = eff_dim(rows_pick, ZZS_MAX_ROWS) * eff_dim(cols_pick, ZZS_MAX_COLS);
      // mostly whole blocks, now and then a ragged count left mid-block
      if ($urandom_range(0, 4) == 0) n_items = $urandom_range(1, total + 2);
      else n_items = total * ((total > 16) ? 1 : $urandom_range(1, 3));
      repeat (n_items) begin
        send_coeff(pick_coeff());
        sent++;
      end
      phase++;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/zzs_pkg.sv
sv/zzs_walk.sv
sv/zigzag_scan_reorder.sv
verif/zigzag_scan_checker.sv
verif/zigzag_scan_reorder_test.sv
